@@ rtl/stbg_pkg.sv @@
// Shared types, constants and the arctangent table for the sine byte generator.
`timescale 1ns / 1ps
package stbg_pkg;

  localparam int CordicSteps   = 24;
  localparam int StepsPerStage = 4;
  localparam int CordicStages  = CordicSteps / StepsPerStage;

  // CORDIC start vector, pre-scaled by the inverse gain
  localparam logic signed [32:0] CordicX0 = 33'sd652032874;
  localparam logic [17:0] SineOne = 18'd131072;

  // Register map, word index
  typedef enum logic [1:0] {
    RegAmplitude = 2'd0,
    RegPhaseStep = 2'd1,
    RegSizeLog2  = 2'd2,
    RegByteMode  = 2'd3
  } stbg_reg_e;

  // Byte count selector codes
  localparam logic [1:0] ModeOneByte = 2'd0;
  localparam logic [1:0] ModeTwoByte = 2'd1;

  // Folded angle request from the front end
  typedef struct packed {
    logic [30:0] t;
    logic [1:0]  quad;
    logic        zero;
  } stbg_req_t;

  // One CORDIC pipeline slot
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
    logic [1:0]         quad;
    logic               zero;
    logic               one;
  } stbg_crd_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_f(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/sine_table_byte_generator.sv @@
// Sine generator: one request in, 1, 2 or 4 big-endian sample bytes out.
// Path: a request passes the queue, 6 CORDIC stages, scale and serializer
// load before its first byte is valid.
// Flow: new requests are taken while earlier ones are in flight; the pace is set by
// the bytes per sample that the byte-wide output port sends and by its ready.
// Reset: phase clears to zero, registers return to their defaults, pipeline empties.
`timescale 1ns / 1ps
module sine_table_byte_generator
  import stbg_pkg::*;
#(
  parameter int INDEX_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [14:0] amp_q;
  logic [31:0] step_q;
  logic [4:0]  size_q;
  logic [1:0]  mode_q;
  logic        wr_en;
  stbg_reg_e   reg_idx;

  logic      q_full, q_push, q_valid, q_pop;
  stbg_req_t q_in, q_out;
  logic        smp_valid, take;
  logic [31:0] sample;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = stbg_reg_e'(paddr[3:2]);

  // register read
  always_comb begin
    case (reg_idx)
      RegAmplitude: prdata = {17'h0, amp_q};
      RegPhaseStep: prdata = step_q;
      RegSizeLog2:  prdata = {27'h0, size_q};
      RegByteMode:  prdata = {30'h0, mode_q};
      default:      prdata = 32'h0;
    endcase
  end

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q  <= 15'd511;
      step_q <= 32'h00010000;
      size_q <= 5'd10;
      mode_q <= ModeTwoByte;
    end else if (wr_en) begin
      case (reg_idx)
        RegAmplitude: amp_q  <= pwdata[14:0];
        RegPhaseStep: step_q <= pwdata;
        RegSizeLog2:  size_q <= pwdata[4:0];
        RegByteMode:  mode_q <= pwdata[1:0];
        default:      ;
      endcase
    end
  end

  stbg_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .restart_i    (s_axis_tdata[0]),
    .phase_step_i (step_q),
    .size_log2_i  (size_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_in)
  );

  stbg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  stbg_sine u_sine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_i       (q_out),
    .pop_o       (q_pop),
    .amplitude_i (amp_q),
    .smp_valid_o (smp_valid),
    .sample_o    (sample),
    .take_i      (take)
  );

  stbg_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_valid_i (smp_valid),
    .sample_i    (sample),
    .take_o      (take),
    .mode_i      (mode_q),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_byte_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule

@@ rtl/stbg_front.sv @@
// Front end: phase accumulator, table index and quadrant folding.
`timescale 1ns / 1ps
module stbg_front
  import stbg_pkg::*;
#(
  parameter int INDEX_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic        restart_i,
  input  logic [31:0] phase_step_i,
  input  logic [4:0]  size_log2_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output stbg_req_t   q_data_o
);

  localparam int Lim = (INDEX_BITS > 16) ? 16 : ((INDEX_BITS < 1) ? 1 : INDEX_BITS);
  localparam logic [4:0] LimL = 5'(Lim);

  logic [31:0] phase_q, phase_d, ph;
  logic [4:0]  sl;
  logic [15:0] mask, idx;
  logic [31:0] angle;
  logic [30:0] rest, t;

  assign req_ready_o = !q_full_i;
  assign q_push_o    = req_valid_i && !q_full_i;

  // index and folded angle
  always_comb begin
    ph    = restart_i ? 32'h0 : phase_q;
    sl    = (size_log2_i > LimL) ? LimL : size_log2_i;
    mask  = 16'hFFFF >> (5'd16 - sl);
    idx   = ph[31:16] & mask;
    angle = {idx, 16'h0000} << (5'd16 - sl);
    rest  = {1'b0, angle[29:0]};
    t     = angle[30] ? (31'h40000000 - rest) : rest;
    q_data_o.t    = t;
    q_data_o.quad = angle[31:30];
    q_data_o.zero = (t == 31'h0);
    phase_d = q_push_o ? (ph + phase_step_i) : phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 32'h0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

@@ rtl/stbg_fifo.sv @@
// Two-entry queue between front end and sine pipeline.
`timescale 1ns / 1ps
module stbg_fifo
  import stbg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  stbg_req_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output stbg_req_t data_o
);

  stbg_req_t  mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ rtl/stbg_sine.sv @@
// Back end: pipelined CORDIC, amplitude scaling and sign.
`timescale 1ns / 1ps
module stbg_sine
  import stbg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  stbg_req_t   req_i,
  output logic        pop_o,
  input  logic [14:0] amplitude_i,
  output logic        smp_valid_o,
  output logic [31:0] sample_o,
  input  logic        take_i
);

  localparam int Last = CordicStages - 1;

  stbg_crd_t crd_q [CordicStages];
  stbg_crd_t crd_d [CordicStages];
  logic [CordicStages-1:0] v_q;
  logic        smp_v_q;
  logic [31:0] sample_q, sample_d;
  logic        adv;
  logic signed [32:0] r;
  logic [17:0] mag;
  logic [32:0] prod;

  // four rotations per stage
  function automatic stbg_crd_t rot_f(input stbg_crd_t c, input int base);
    stbg_crd_t o;
    logic signed [32:0] nx, ny;
    o = c;
    for (int j = 0; j < StepsPerStage; j++) begin
      if (o.z >= 0) begin
        nx  = o.x - (o.y >>> (base + j));
        ny  = o.y + (o.x >>> (base + j));
        o.z = o.z - $signed(atan_f(base + j));
      end else begin
        nx  = o.x + (o.y >>> (base + j));
        ny  = o.y - (o.x >>> (base + j));
        o.z = o.z + $signed(atan_f(base + j));
      end
      o.x = nx;
      o.y = ny;
    end
    return o;
  endfunction

  assign adv         = !smp_v_q || take_i;
  assign pop_o       = adv && req_valid_i;
  assign smp_valid_o = smp_v_q;
  assign sample_o    = sample_q;

  // stage inputs
  always_comb begin
    stbg_crd_t s0;
    s0.x    = CordicX0;
    s0.y    = 33'sd0;
    s0.z    = $signed({1'b0, req_i.t});
    s0.quad = req_i.quad;
    s0.zero = req_i.zero;
    s0.one  = req_i.t[30];
    crd_d[0] = rot_f(s0, 0);
    for (int s = 1; s < CordicStages; s++) begin
      crd_d[s] = rot_f(crd_q[s-1], s * StepsPerStage);
    end
  end

  // rounding, clamp, scale, sign
  always_comb begin
    r = (crd_q[Last].y + 33'sd4096) >>> 13;
    if (crd_q[Last].zero || r < 0) begin
      mag = 18'd0;
    end else if (crd_q[Last].one || r > $signed({15'd0, SineOne})) begin
      mag = SineOne;
    end else begin
      mag = r[17:0];
    end
    prod     = {18'd0, amplitude_i} * {15'd0, mag};
    sample_d = crd_q[Last].quad[1] ? (32'h0 - {16'h0, prod[32:17]}) : {16'h0, prod[32:17]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      smp_v_q <= 1'b0;
    end else if (adv) begin
      v_q     <= {v_q[CordicStages-2:0], req_valid_i};
      smp_v_q <= v_q[Last];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < CordicStages; s++) begin
        crd_q[s] <= crd_d[s];
      end
      sample_q <= sample_d;
    end
  end

endmodule

@@ rtl/stbg_ser.sv @@
// Byte serializer: sends a sample most significant byte first.
`timescale 1ns / 1ps
module stbg_ser
  import stbg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        smp_valid_i,
  input  logic [31:0] sample_i,
  output logic        take_o,
  input  logic [1:0]  mode_i,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [7:0]  m_byte_o,
  output logic        m_last_o
);

  logic [2:0]  rem_q, rem_d, nb;
  logic [31:0] smp_q;
  logic [1:0]  sel;
  logic        load;

  assign take_o    = (rem_q == 3'd0) || (rem_q == 3'd1 && m_ready_i);
  assign load      = smp_valid_i && take_o;
  assign m_valid_o = (rem_q != 3'd0);
  assign m_last_o  = (rem_q == 3'd1);
  assign sel       = rem_q[1:0] - 2'd1;
  assign m_byte_o  = smp_q[8*sel +: 8];

  always_comb begin
    case (mode_i)
      ModeOneByte: nb = 3'd1;
      ModeTwoByte: nb = 3'd2;
      default:     nb = 3'd4;
    endcase
    if (load) begin
      rem_d = nb;
    end else if (m_valid_o && m_ready_i) begin
      rem_d = rem_q - 3'd1;
    end else begin
      rem_d = rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      smp_q <= sample_i;
    end
  end

endmodule

@@ rtl/stbg_checker.sv @@
// Port-level checks for the sine byte generator, bound to the top level.
`timescale 1ns / 1ps
module stbg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       pready
);

  // stalled byte holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output byte changed");

  // rest of a sample follows without a gap
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("sample bytes interrupted");

  // nothing pending right after reset
  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  // config port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind sine_table_byte_generator stbg_checker u_stbg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);
